@@ src/efcrc5_pkg.sv @@
`timescale 1ns / 1ps

package efcrc5_pkg;

    localparam int FRAME_BYTES_DEF = 6;
    localparam int RX_WIDTH        = 48;
    localparam int WORD_BITS       = 32;
    localparam int PAYLOAD_BITS    = 15;
    localparam int CRC_BITS        = 5;
    localparam int FIELD_BITS      = PAYLOAD_BITS + CRC_BITS;
    localparam int POS_BITS        = 13;
    localparam int ALARM_BITS      = 2;
    localparam int CNT_BITS        = 4;
    localparam int START_IDX_BITS  = 2;

    localparam logic [CNT_BITS-1:0] MAX_FAIL_RESET = 4'd10;
    localparam logic [CRC_BITS-1:0] CRC_SEED       = 5'h1F;

    typedef enum logic [1:0] {
        ST_GOOD    = 2'd0,
        ST_CRC_ERR = 2'd1,
        ST_FRAMING = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_BITS = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

endpackage

@@ src/encoder_frame_crc5_decode.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake                    Payload
// rx        in         i_rx_valid / o_rx_ready      i_rx_frame
// res       out        o_res_valid / i_res_ready    o_position, o_alarm_bits,
//                                                   o_frame_status,
//                                                   o_failure_count, o_link_error
// cfg       in         i_cfg_valid / o_cfg_ready    i_cfg_max_failures
//
// Steps: the frame is scanned byte by byte for the start byte (1 to
// FRAME_BYTES-4 bytes scanned), then the reversed word is walked bit by bit
// up to and including the start bit (1 to 32 bits), the 20-bit field is
// captured serially and the supervision state is updated.
// A framing error skips the bit walk and the field capture.
// Reset (synchronous, active low) clears held position, alarm bits, failure
// count, sticky error and sets max_failures to 10.
// A finished result waits in the output register; the next frame transfer is
// taken meanwhile, and its final update stalls until the result is taken.

module encoder_frame_crc5_decode #(
    parameter int FRAME_BYTES = efcrc5_pkg::FRAME_BYTES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // frame input
    input  logic                                 i_rx_valid,
    output logic                                 o_rx_ready,
    input  logic [efcrc5_pkg::RX_WIDTH-1:0]      i_rx_frame,
    // result output
    output logic                                 o_res_valid,
    input  logic                                 i_res_ready,
    output logic [efcrc5_pkg::POS_BITS-1:0]      o_position,
    output logic [efcrc5_pkg::ALARM_BITS-1:0]    o_alarm_bits,
    output logic [1:0]                           o_frame_status,
    output logic [efcrc5_pkg::CNT_BITS-1:0]      o_failure_count,
    output logic                                 o_link_error,
    // configuration
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [efcrc5_pkg::CNT_BITS-1:0]      i_cfg_max_failures
);
    import efcrc5_pkg::*;

    // last start-byte index that still leaves four bytes after it
    localparam logic [START_IDX_BITS-1:0] LAST_IDX = START_IDX_BITS'(FRAME_BYTES - 5);
    localparam int BCNT_BITS = $clog2(WORD_BITS);
    localparam int NCOL_BITS = $clog2(FIELD_BITS + 1);
    localparam logic [BCNT_BITS-1:0] BCNT_LAST = BCNT_BITS'(WORD_BITS - 1);
    localparam logic [NCOL_BITS-1:0] NCOL_LAST = NCOL_BITS'(FIELD_BITS - 1);
    localparam logic [NCOL_BITS-1:0] NCOL_PAY  = NCOL_BITS'(PAYLOAD_BITS);

    t_state                     r_state;
    logic [RX_WIDTH-1:0]        r_frame;
    logic [START_IDX_BITS-1:0]  r_idx;
    logic                       r_ferr;
    logic [WORD_BITS-1:0]       r_word;
    logic [BCNT_BITS-1:0]       r_bcnt;
    logic                       r_started;
    logic [NCOL_BITS-1:0]       r_ncol;
    logic [FIELD_BITS-1:0]      r_field;
    logic [CRC_BITS-1:0]        r_crc;
    logic [CRC_BITS-1:0]        n_crc;
    logic [WORD_BITS-1:0]       n_word;

    logic [POS_BITS-1:0]        r_held_pos;
    logic [ALARM_BITS-1:0]      r_held_alarm;
    logic [CNT_BITS-1:0]        r_fail_cnt;
    logic                       r_link_err;
    logic [CNT_BITS-1:0]        r_max_fail;
    logic [1:0]                 r_status;
    logic                       r_out_valid;

    logic                       bit_in;
    logic                       crc_ex;
    logic [CRC_BITS-1:0]        crc_calc;
    logic                       slot_free;
    logic                       frame_bad;

    assign o_rx_ready      = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_res_valid     = r_out_valid;
    assign o_position      = r_held_pos;
    assign o_alarm_bits    = r_held_alarm;
    assign o_frame_status  = r_status;
    assign o_failure_count = r_fail_cnt;
    assign o_link_error    = r_link_err;

    // Word bit 8n+j is bit 7-j of byte k+n: per-byte reversal is wiring.
    // Bits 7:6 of the start byte are cleared, i.e. word bits 1:0.
    always_comb begin
        for (int n = 0; n < 4; n++) begin
            for (int j = 0; j < 8; j++) begin
                n_word[8*n+j] = r_frame[8*n+7-j];
            end
        end
        n_word[1:0] = 2'b00;
    end

    // serial CRC-5, taps after stages 0 and 2
    assign bit_in = r_word[0];
    assign crc_ex = r_crc[4] ^ bit_in;
    always_comb begin
        n_crc[0] = crc_ex;
        n_crc[1] = r_crc[0] ^ crc_ex;
        n_crc[2] = r_crc[1];
        n_crc[3] = r_crc[2] ^ crc_ex;
        n_crc[4] = r_crc[3];
    end
    // complemented, stage 0 read as MSB
    assign crc_calc = ~{r_crc[0], r_crc[1], r_crc[2], r_crc[3], r_crc[4]};

    assign slot_free = !r_out_valid || i_res_ready;
    assign frame_bad = r_ferr || (crc_calc != r_field[FIELD_BITS-1:PAYLOAD_BITS]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_held_pos   <= '0;
            r_held_alarm <= '0;
            r_fail_cnt   <= '0;
            r_link_err   <= 1'b0;
            r_max_fail   <= MAX_FAIL_RESET;
            r_status     <= ST_GOOD;
            r_ferr       <= 1'b0;
            r_ncol       <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_max_fail <= i_cfg_max_failures;
            end
            // in S_DONE the update below decides the valid flag
            if (r_out_valid && i_res_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_rx_valid) begin
                        r_frame <= i_rx_frame;
                        r_idx   <= '0;
                        r_ferr  <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                // one byte per cycle looking for the start byte
                S_SCAN: begin
                    if (r_frame[7:0] != 8'h00) begin
                        r_word    <= n_word;
                        r_bcnt    <= '0;
                        r_started <= 1'b0;
                        r_ncol    <= '0;
                        r_crc     <= CRC_SEED;
                        r_state   <= S_BITS;
                    end else if (r_idx == LAST_IDX) begin
                        r_ferr  <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_frame <= r_frame >> 8;
                        r_idx   <= r_idx + 1'b1;
                    end
                end
                // walk the word LSB first: skip zeros and start bit, then
                // capture 15 payload bits and 5 CRC bits; zeros past the end
                S_BITS: begin
                    r_word <= r_word >> 1;
                    if (!r_started) begin
                        // an all-zero word takes its last bit as the start
                        if (bit_in || r_bcnt == BCNT_LAST) begin
                            r_started <= 1'b1;
                        end
                        r_bcnt <= r_bcnt + 1'b1;
                    end else begin
                        r_field <= {bit_in, r_field[FIELD_BITS-1:1]};
                        if (r_ncol < NCOL_PAY) begin
                            r_crc <= n_crc;
                        end
                        r_ncol <= r_ncol + 1'b1;
                        if (r_ncol == NCOL_LAST) begin
                            r_state <= S_DONE;
                        end
                    end
                end
                // update supervision state once the output slot is free
                S_DONE: begin
                    if (slot_free) begin
                        if (frame_bad) begin
                            if (r_fail_cnt < r_max_fail) begin
                                r_fail_cnt <= r_fail_cnt + 1'b1;
                            end else begin
                                r_link_err <= 1'b1;
                            end
                            r_status <= r_ferr ? ST_FRAMING : ST_CRC_ERR;
                        end else begin
                            r_held_pos   <= r_field[PAYLOAD_BITS-1:ALARM_BITS];
                            r_held_alarm <= r_field[ALARM_BITS-1:0];
                            r_fail_cnt   <= '0;
                            r_status     <= ST_GOOD;
                        end
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // sticky error stays set until reset
    a_link_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_link_err |=> r_link_err)
        else $error("link error cleared without reset");

    // a good frame always reports a cleared failure count
    a_good_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_frame_status == ST_GOOD) |-> (o_failure_count == '0))
        else $error("good frame with nonzero failure count");

    // a decoded frame reaches the update only with the whole field captured
    a_field_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_ferr) |-> (r_ncol == NCOL_BITS'(FIELD_BITS)))
        else $error("field capture incomplete at update");

    // while a result waits, its failure count and status hold
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !i_res_ready) |=>
            ($stable(o_failure_count) && $stable(o_frame_status)))
        else $error("pending result changed");

endmodule

@@ tb/sv/efcrc5_tb_pkg.sv @@
`timescale 1ns / 1ps

package efcrc5_tb_pkg;

    // Mirror of one received byte.
    function automatic logic [7:0] bit_reverse8(input logic [7:0] b);
        logic [7:0] r;
        int n;
        for (n = 0; n < 8; n++) begin
            r[7-n] = b[n];
        end
        return r;
    endfunction

    // Serial CRC-5, taps after stages 0 and 2, seeded all ones, data LSB first,
    // complemented on the way out with stage 0 as MSB.
    function automatic logic [4:0] crc5_serial(input logic [14:0] data);
        logic [4:0] sr;
        logic       fb;
        int         n;
        sr = '1;
        for (n = 0; n < 15; n++) begin
            fb = sr[4] ^ data[n];
            sr = {sr[3], sr[2] ^ fb, sr[1], sr[0] ^ fb, fb};
        end
        return {~sr[0], ~sr[1], ~sr[2], ~sr[3], ~sr[4]};
    endfunction

endpackage

@@ tb/sv/efcrc5_frame_checker.sv @@
`timescale 1ns / 1ps

module efcrc5_frame_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_rx_valid,
    input  logic                              i_rx_ready,
    input  logic [efcrc5_pkg::RX_WIDTH-1:0]   i_rx_frame,
    input  logic                              i_res_valid,
    input  logic                              i_res_ready,
    input  logic [efcrc5_pkg::POS_BITS-1:0]   i_position,
    input  logic [efcrc5_pkg::ALARM_BITS-1:0] i_alarm_bits,
    input  logic [1:0]                        i_frame_status,
    input  logic [efcrc5_pkg::CNT_BITS-1:0]   i_failure_count,
    input  logic                              i_link_error,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [efcrc5_pkg::CNT_BITS-1:0]   i_cfg_max_failures,
    output int                                o_mismatches,
    output int                                o_pending
);
    import efcrc5_pkg::*;
    import efcrc5_tb_pkg::*;

    localparam int NBYTES = FRAME_BYTES_DEF;

    typedef struct packed {
        logic [POS_BITS-1:0]   position;
        logic [ALARM_BITS-1:0] alarm;
        t_status               status;
        logic [CNT_BITS-1:0]   fails;
        logic                  link_err;
    } t_frame_result;

    logic [POS_BITS-1:0]   held_pos;
    logic [ALARM_BITS-1:0] held_alarm;
    logic [CNT_BITS-1:0]   fail_cnt;
    logic                  err_latch;
    logic [CNT_BITS-1:0]   max_fail;
    t_frame_result         frame_results_due[$];
    int                    mismatch_cnt = 0;

    assign o_mismatches = mismatch_cnt;

    function automatic void count_failure();
        if (fail_cnt < max_fail) begin
            fail_cnt = fail_cnt + 1'b1;
        end else begin
            err_latch = 1'b1;
        end
    endfunction

    function automatic t_frame_result decode_frame(input logic [RX_WIDTH-1:0] frame);
        logic [7:0]    bytes_in [NBYTES];
        logic [31:0]   w;
        logic [19:0]   fld;
        logic [14:0]   pl;
        t_status       st;
        t_frame_result r;
        int            start_at;
        int            n;
        start_at = NBYTES;
        for (n = 0; n < NBYTES; n++) begin
            bytes_in[n] = frame[8*n +: 8];
        end
        for (n = NBYTES - 1; n >= 0; n--) begin
            if (bytes_in[n] != 8'h00) begin
                start_at = n;
            end
        end
        if (NBYTES - start_at > 4) begin
            bytes_in[start_at][7:6] = 2'b00;
            w = '0;
            for (n = 0; n < 4; n++) begin
                w[8*n +: 8] = bit_reverse8(bytes_in[start_at + n]);
            end
            if (w != 0) begin
                while (!w[0]) begin
                    w = w >> 1;
                end
            end
            fld = w[20:1];
            pl  = fld[14:0];
            if (crc5_serial(pl) == fld[19:15]) begin
                held_alarm = pl[1:0];
                held_pos   = pl[14:2];
                fail_cnt   = '0;
                st         = ST_GOOD;
            end else begin
                count_failure();
                st = ST_CRC_ERR;
            end
        end else begin
            count_failure();
            st = ST_FRAMING;
        end
        r.position = held_pos;
        r.alarm    = held_alarm;
        r.status   = st;
        r.fails    = fail_cnt;
        r.link_err = err_latch;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_frame_result got;
        t_frame_result want;
        if (!i_rst_n) begin
            held_pos   = '0;
            held_alarm = '0;
            fail_cnt   = '0;
            err_latch  = 1'b0;
            max_fail   = MAX_FAIL_RESET;
            frame_results_due.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                max_fail = i_cfg_max_failures;
            end
            // result side first: a frame taken at this edge cannot answer at it
            if (i_res_valid && i_res_ready) begin
                got.position = i_position;
                got.alarm    = i_alarm_bits;
                got.status   = t_status'(i_frame_status);
                got.fails    = i_failure_count;
                got.link_err = i_link_error;
                if (frame_results_due.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("%0t: result transfer with no frame outstanding", $time);
                    end
                end else begin
                    want = frame_results_due.pop_front();
                    if (got.position !== want.position || got.alarm !== want.alarm ||
                        got.status !== want.status || got.fails !== want.fails ||
                        got.link_err !== want.link_err) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $display("%0t: mismatch exp pos=%0d alarm=%0d st=%0d cnt=%0d err=%0b",
                                     $time, want.position, want.alarm, want.status,
                                     want.fails, want.link_err);
                            $display("%0t:          got pos=%0d alarm=%0d st=%0d cnt=%0d err=%0b",
                                     $time, got.position, got.alarm, got.status,
                                     got.fails, got.link_err);
                        end
                    end
                end
            end
            if (i_rx_valid && i_rx_ready) begin
                frame_results_due.push_back(decode_frame(i_rx_frame));
            end
            o_pending <= frame_results_due.size();
        end
    end

endmodule

@@ tb/sv/tb_encoder_frame_crc5_decode.sv @@
`timescale 1ns / 1ps

module tb_encoder_frame_crc5_decode;
    import efcrc5_pkg::*;
    import efcrc5_tb_pkg::*;

    // Run length guard. Even with heavy stalls on both sides, ~800 frames
    // stay far below this.
    localparam int unsigned CYCLE_LIMIT     = 1_000_000;
    // Settle time after the last result.
    localparam int          SETTLE_CYCLES   = 120;
    localparam int          ITEMS_PER_PHASE = 150;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_rx_valid;
    logic                  o_rx_ready;
    logic [RX_WIDTH-1:0]   i_rx_frame;
    logic                  o_res_valid;
    logic                  i_res_ready;
    logic [POS_BITS-1:0]   o_position;
    logic [ALARM_BITS-1:0] o_alarm_bits;
    logic [1:0]            o_frame_status;
    logic [CNT_BITS-1:0]   o_failure_count;
    logic                  o_link_error;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CNT_BITS-1:0]   i_cfg_max_failures;

    int          n_mismatch;
    int          n_pending;
    int          stall_pct  = 0;   // receiver stall chance per cycle, percent
    int          fail_burst = 0;   // frames left in a forced run of failures
    int unsigned cycle_cnt  = 0;

    encoder_frame_crc5_decode u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_rx_valid         (i_rx_valid),
        .o_rx_ready         (o_rx_ready),
        .i_rx_frame         (i_rx_frame),
        .o_res_valid        (o_res_valid),
        .i_res_ready        (i_res_ready),
        .o_position         (o_position),
        .o_alarm_bits       (o_alarm_bits),
        .o_frame_status     (o_frame_status),
        .o_failure_count    (o_failure_count),
        .o_link_error       (o_link_error),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_max_failures (i_cfg_max_failures)
    );

    // Watches all three channels, predicts every result and compares.
    efcrc5_frame_checker u_chk (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_rx_valid         (i_rx_valid),
        .i_rx_ready         (o_rx_ready),
        .i_rx_frame         (i_rx_frame),
        .i_res_valid        (o_res_valid),
        .i_res_ready        (i_res_ready),
        .i_position         (o_position),
        .i_alarm_bits       (o_alarm_bits),
        .i_frame_status     (o_frame_status),
        .i_failure_count    (o_failure_count),
        .i_link_error       (o_link_error),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_ready        (o_cfg_ready),
        .i_cfg_max_failures (i_cfg_max_failures),
        .o_mismatches       (n_mismatch),
        .o_pending          (n_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop if the block hangs or drops a frame.
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("tb_encoder_frame_crc5_decode: FAIL");
        $finish;
    end

    // Result side: ready rolls every cycle against the phase's stall chance.
    initial begin
        i_res_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            i_res_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Builds a frame that carries payload behind a start bit with tz trailing
    // zeros (2..11), starting at byte start_at (0 or 1). corrupt flips one bit
    // of the 20-bit field so the check must fail. Bits above the field and the
    // two start-byte bits that the decoder clears are filled with noise.
    function automatic logic [RX_WIDTH-1:0] make_frame(input logic [14:0] payload,
                                                       input bit corrupt,
                                                       input int start_at,
                                                       input int tz);
        logic [19:0]         fld;
        logic [31:0]         w;
        logic [31:0]         keep;
        logic [RX_WIDTH-1:0] f;
        int                  flip;
        int                  n;
        fld = {crc5_serial(payload), payload};
        if (corrupt) begin
            flip      = $urandom_range(19);
            fld[flip] = ~fld[flip];
        end
        w    = {11'b0, fld, 1'b1} << tz;
        keep = (tz >= 11) ? '1 : ((32'h1 << (21 + tz)) - 1);
        w    = (w & keep) | ($urandom() & ~keep);
        // start byte must stay nonzero; when the field sits high, only the
        // two cleared bits can mark it
        if (w[7:2] == 6'b0) begin
            w[1:0] = 2'($urandom_range(1, 3));
        end else begin
            w[1:0] = 2'($urandom_range(0, 3));
        end
        f = {16'($urandom()), 32'($urandom())};
        if (start_at == 1) begin
            f[7:0] = 8'h00;
        end
        for (n = 0; n < 4; n++) begin
            f[8*(start_at + n) +: 8] = bit_reverse8(w[8*n +: 8]);
        end
        return f;
    endfunction

    // Mostly well-formed frames, with runs of failures to walk the counter up
    // to the limit, framing errors and raw noise.
    function automatic logic [RX_WIDTH-1:0] next_random_frame();
        int                  pick;
        logic [RX_WIDTH-1:0] f;
        pick = $urandom_range(99);
        if (fail_burst > 0) begin
            fail_burst--;
            pick = ($urandom_range(9) < 7) ? 65 : 80;
        end else if ($urandom_range(29) == 0) begin
            fail_burst = $urandom_range(12, 18);
        end
        if (pick < 60) begin
            f = make_frame(15'($urandom()), 1'b0, $urandom_range(1), $urandom_range(2, 11));
        end else if (pick < 75) begin
            f = make_frame(15'($urandom()), 1'b1, $urandom_range(1), $urandom_range(2, 11));
        end else if (pick < 85) begin
            // no start byte in the first two
            f = ($urandom_range(3) == 0) ? '0 : {32'($urandom()), 16'h0000};
        end else begin
            f = {16'($urandom()), 32'($urandom())};
        end
        return f;
    endfunction

    // Present one frame and hold it until the transfer. valid stays high on
    // return so a back-to-back frame needs no extra edge.
    task automatic send_frame(input logic [RX_WIDTH-1:0] f);
        i_rx_valid <= 1'b1;
        i_rx_frame <= f;
        @(posedge i_clk);
        while (!o_rx_ready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic sender_gap(input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            i_rx_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Every frame has exactly one result, so zero outstanding means idle.
    // The count is registered in the checker, hence the edge before the test.
    task automatic wait_drained();
        i_rx_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (n_pending != 0);
    endtask

    task automatic write_max_failures(input logic [CNT_BITS-1:0] v);
        i_cfg_valid        <= 1'b1;
        i_cfg_max_failures <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [CNT_BITS-1:0] max_fail, input int send_idle,
                             input int recv_stall);
        int i;
        write_max_failures(max_fail);
        stall_pct = recv_stall;
        for (i = 0; i < ITEMS_PER_PHASE; i++) begin
            send_frame(next_random_frame());
            sender_gap(send_idle);
        end
        wait_drained();
    endtask

    initial begin
        logic [RX_WIDTH-1:0] directed [$];

        i_rst_n            <= 1'b0;
        i_rx_valid         <= 1'b0;
        i_rx_frame         <= '0;
        i_cfg_valid        <= 1'b0;
        i_cfg_max_failures <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frames, run at the reset limit of ten failures.
        directed.push_back(48'h0000_0000_0000);              // empty frame
        directed.push_back(48'hFFFF_FFFF_FFFF);              // all ones
        directed.push_back(48'h8000_0000_0000);              // start in last byte
        directed.push_back(48'h0000_0001_0000);              // start in byte 2
        directed.push_back(48'h0000_0000_00C0);              // marker bits only, word zero
        directed.push_back(48'h0000_0000_4000);              // same, start in byte 1
        directed.push_back(make_frame(15'h0000, 1'b0, 0, 2));
        directed.push_back(make_frame(15'h7FFF, 1'b0, 0, 11));
        directed.push_back(make_frame(15'h5555, 1'b0, 1, 2));
        directed.push_back(make_frame(15'h2AAA, 1'b0, 1, 11));
        directed.push_back(make_frame(15'h1234, 1'b0, 0, 9)); // start byte is marker only
        directed.push_back(make_frame(15'h4321, 1'b0, 1, 8)); // same, start in byte 1
        directed.push_back(make_frame(15'h0F0F, 1'b1, 0, 5)); // CRC broken
        directed.push_back(make_frame(15'h70F0, 1'b1, 1, 3)); // CRC broken
        directed.push_back(make_frame(15'h0001, 1'b0, 0, 4)); // good frame clears count
        foreach (directed[i]) begin
            send_frame(directed[i]);
        end
        wait_drained();

        // Random phases: limit setting, sender idle %, receiver stall %.
        run_phase(4'd15, 0, 0);
        run_phase(4'd2, 84, 0);
        run_phase(4'd0, 0, 84);
        run_phase(4'($urandom_range(15)), 18, 18);
        run_phase(4'd10, 0, 0);

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (n_mismatch == 0 && n_pending == 0) begin
            $display("tb_encoder_frame_crc5_decode: PASS");
        end else begin
            $display("tb_encoder_frame_crc5_decode: FAIL");
        end
        $finish;
    end

endmodule
